// ===== hdl/jddc_pkg.sv =====
package jddc_pkg;

    localparam int NSTG = 15;

    localparam logic [22:0] JDN_BASE       = 23'd1721060;
    localparam logic [13:0] YEAR_LIMIT_RST = 14'd9999;

    // reciprocals: q = (n * RECIP) >> shift, low by at most one where RECIP is rounded down
    localparam logic [12:0] RECIP_100     = 13'd5243;   // >> 19, exact below 43690
    localparam logic [14:0] RECIP_146097  = 15'd29398;  // >> 32
    localparam logic [11:0] RECIP_1461001 = 12'd2939;   // >> 32
    localparam logic [8:0]  RECIP_2447    = 9'd428;     // >> 20

    localparam logic [17:0] DAYS_400Y  = 18'd146097;
    localparam logic [20:0] DAYS_4000Y = 21'd1461001;
    localparam logic [11:0] D_2447     = 12'd2447;

    typedef enum logic {
        OP_ENCODE = 1'b0,
        OP_DECODE = 1'b1
    } t_op;

    typedef struct packed {
        logic        operation;
        logic [13:0] year_in;
        logic [3:0]  month_in;
        logic [4:0]  day_in;
        logic [22:0] julian_in;
    } t_req;

    typedef struct packed {
        logic [22:0] julian_out;
        logic [14:0] year_out;
        logic [3:0]  month_out;
        logic [4:0]  day_out;
        logic [2:0]  day_of_week;
    } t_rsp;

    typedef struct packed {
        logic [NSTG-1:0] adv;
    } t_ctl;

    typedef struct packed {
        logic        op;
        logic        below;
        logic [13:0] y;
        logic [3:0]  m;
        logic [4:0]  d;
        logic [22:0] jin;
        // encode
        logic        rng_ok;
        logic        short_ok;
        logic        feb29;
        logic        ok;
        logic [14:0] ya;
        logic [8:0]  eb;
        logic [26:0] yp;
        logic [7:0]  yq;
        logic [24:0] ap;
        logic [26:0] cp;
        logic [22:0] a;
        logic [7:0]  c;
        logic [22:0] jde;
        // decode
        logic [23:0] l0;
        logic [40:0] wp;
        logic [8:0]  w;
        logic [18:0] r;
        logic [15:0] l1;
        logic [27:0] nx;
        logic [39:0] xp;
        logic [7:0]  x;
        logic [21:0] rx;
        logic [9:0]  l2;
        logic [16:0] vn;
        logic [25:0] vp;
        logic [5:0]  v;
        logic [12:0] rv;
        // weekday
        logic [5:0]  s6;
        logic [2:0]  dow;
        t_rsp        rsp;
    } t_stg;

    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // (mm * 367) / 12 with March as month one
    function automatic logic [8:0] enc_mday(input logic [3:0] m);
        logic [8:0] val;
        unique case (m)
            4'd1:    val = 9'd336;
            4'd2:    val = 9'd367;
            4'd3:    val = 9'd30;
            4'd4:    val = 9'd61;
            4'd5:    val = 9'd91;
            4'd6:    val = 9'd122;
            4'd7:    val = 9'd152;
            4'd8:    val = 9'd183;
            4'd9:    val = 9'd214;
            4'd10:   val = 9'd244;
            4'd11:   val = 9'd275;
            4'd12:   val = 9'd305;
            default: val = 9'd0;
        endcase
        return val;
    endfunction

    // (2447 * v) / 80
    function automatic logic [8:0] dec_mday(input logic [3:0] v);
        logic [8:0] val;
        unique case (v)
            4'd0:    val = 9'd0;
            4'd1:    val = 9'd30;
            4'd2:    val = 9'd61;
            4'd3:    val = 9'd91;
            4'd4:    val = 9'd122;
            4'd5:    val = 9'd152;
            4'd6:    val = 9'd183;
            4'd7:    val = 9'd214;
            4'd8:    val = 9'd244;
            4'd9:    val = 9'd275;
            4'd10:   val = 9'd305;
            4'd11:   val = 9'd336;
            4'd12:   val = 9'd367;
            4'd13:   val = 9'd397;
            4'd14:   val = 9'd428;
            default: val = 9'd458;
        endcase
        return val;
    endfunction

    // sum of octal digits, congruent mod 7
    function automatic logic [5:0] oct_fold(input logic [23:0] val);
        logic [5:0] acc;
        acc = '0;
        for (int i = 0; i < 8; i++) begin
            acc = acc + 6'(val[3*i +: 3]);
        end
        return acc;
    endfunction

endpackage

// ===== hdl/jddc_if.sv =====
interface jddc_req_if import jddc_pkg::*; ();
    logic valid;
    logic ready;
    t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface jddc_rsp_if import jddc_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/jddc_pipe_ctl.sv =====
module jddc_pipe_ctl import jddc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_ctl o_ctl
);

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;
    logic [NSTG-1:0] adv;

    // a stage loads when empty or when the one after it moves on
    always_comb begin
        adv[NSTG-1] = !r_vld[NSTG-1] || i_out_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
        n_vld[0] = adv[0] ? i_in_valid : r_vld[0];
        for (int k = 1; k < NSTG; k++) begin
            n_vld[k] = adv[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_ready  = adv[0];
    assign o_out_valid = r_vld[NSTG-1];
    assign o_ctl.adv   = adv;

endmodule

// ===== hdl/julian_day_date_converter.sv =====
// Channel   Dir  Beat                                Handshake
// i_req     in   operation, date, julian_in          valid/ready
// o_rsp     out  julian_out, year/month/day, weekday valid/ready
// i_cfg_*   in   year_limit (14 bits)                write enable
//
// Fifteen register stages; one beat accepted per cycle unless a stall on o_rsp backs up to the input.
// The pipeline depth is set by the decode chain: three reciprocal divisions, each a
// multiply stage followed by a remainder stage and a correction stage.
// Synchronous active-low reset empties the pipeline and sets year_limit to 9999.
// A stall on o_rsp holds the full stages; empty stages ahead still fill.
module julian_day_date_converter import jddc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    jddc_req_if.sink    i_req,
    jddc_rsp_if.source  o_rsp,
    input  logic        i_cfg_we,
    input  logic [13:0] i_cfg_wdata
);

    logic [13:0] r_year_limit;
    t_stg        r_stg [NSTG];
    t_stg        n_stg [NSTG];
    t_ctl        ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_year_limit <= YEAR_LIMIT_RST;
        end else if (i_cfg_we) begin
            r_year_limit <= i_cfg_wdata;
        end
    end

    jddc_pipe_ctl u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_ctl       (ctl)
    );

    always_comb begin
        logic [13:0] tmp_y100;
        logic        tmp_leap;
        logic [9:0]  tmp_c3;
        logic [26:0] tmp_wd;
        logic [25:0] tmp_r;
        logic [23:0] tmp_jd;
        logic [26:0] tmp_q;
        logic [23:0] tmp_l;
        logic [22:0] tmp_src;
        logic [3:0]  tmp_t;
        logic [2:0]  tmp_t2;
        logic [2:0]  tmp_res;
        logic [28:0] tmp_xd;
        logic [28:0] tmp_rx;
        logic [18:0] tmp_p;
        logic [16:0] tmp_l2;
        logic [17:0] tmp_vd;
        logic [17:0] tmp_rv;
        logic        tmp_u;
        logic [15:0] tmp_yr;
        logic [9:0]  tmp_dd;

        for (int k = 1; k < NSTG; k++) begin
            n_stg[k] = r_stg[k-1];
        end

        // stage 0: range checks, year shift, first products
        n_stg[0]          = '0;
        n_stg[0].op       = i_req.payload.operation;
        n_stg[0].y        = i_req.payload.year_in;
        n_stg[0].m        = i_req.payload.month_in;
        n_stg[0].d        = i_req.payload.day_in;
        n_stg[0].jin      = i_req.payload.julian_in;
        n_stg[0].rng_ok   = (i_req.payload.year_in <= r_year_limit)
                            && (i_req.payload.month_in >= 4'd1)
                            && (i_req.payload.month_in <= 4'd12)
                            && (i_req.payload.day_in != 5'd0);
        n_stg[0].short_ok = i_req.payload.day_in <= month_len(i_req.payload.month_in);
        n_stg[0].feb29    = (i_req.payload.day_in == 5'd29)
                            && (i_req.payload.month_in == 4'd2);
        n_stg[0].ya       = (i_req.payload.month_in < 4'd3)
                            ? 15'(i_req.payload.year_in) + 15'd4799
                            : 15'(i_req.payload.year_in) + 15'd4800;
        n_stg[0].eb       = enc_mday(i_req.payload.month_in);
        n_stg[0].yp       = 27'(i_req.payload.year_in) * 27'(RECIP_100);
        n_stg[0].l0       = 24'(i_req.payload.julian_in) + 24'd68569;
        n_stg[0].below    = i_req.payload.julian_in < JDN_BASE;

        // stage 1
        n_stg[1].yq = r_stg[0].yp[26:19];
        n_stg[1].ap = 25'(r_stg[0].ya) * 25'd1461;
        n_stg[1].cp = 27'(r_stg[0].ya + 15'd100) * 27'(RECIP_100);
        n_stg[1].wp = 41'({r_stg[0].l0, 2'b00}) * 41'(RECIP_146097);

        // stage 2: leap year, date valid, 400-year estimate remainder
        tmp_y100    = 14'(r_stg[1].yq) * 14'd100;
        tmp_leap    = (r_stg[1].y[1:0] == 2'd0)
                      && ((tmp_y100 != r_stg[1].y) || (r_stg[1].yq[1:0] == 2'd0));
        n_stg[2].ok = r_stg[1].rng_ok && (r_stg[1].short_ok || (r_stg[1].feb29 && tmp_leap));
        n_stg[2].a  = r_stg[1].ap[24:2];
        tmp_c3      = 10'(r_stg[1].cp[26:19]) * 10'd3;
        n_stg[2].c  = tmp_c3[9:2];
        n_stg[2].w  = r_stg[1].wp[40:32];
        tmp_wd      = 27'(r_stg[1].wp[40:32]) * 27'(DAYS_400Y);
        tmp_r       = {r_stg[1].l0, 2'b00} - tmp_wd[25:0];
        n_stg[2].r  = tmp_r[18:0];

        // stage 3
        tmp_jd        = 24'(r_stg[2].a) + 24'(r_stg[2].eb) + 24'(r_stg[2].d)
                        - 24'(r_stg[2].c) - 24'd32075;
        n_stg[3].jde  = r_stg[2].ok ? tmp_jd[22:0] : 23'd0;
        n_stg[3].w    = r_stg[2].w + 9'(r_stg[2].r >= 19'(DAYS_400Y));

        // stage 4: day within 400-year cycle, weekday digit sum
        tmp_q          = 27'(r_stg[3].w) * 27'(DAYS_400Y) + 27'd3;
        tmp_l          = r_stg[3].l0 - tmp_q[25:2];
        n_stg[4].l1    = tmp_l[15:0];
        tmp_src        = (r_stg[3].op == OP_DECODE) ? r_stg[3].jin : r_stg[3].jde;
        n_stg[4].below = tmp_src < JDN_BASE;
        n_stg[4].s6    = oct_fold(24'(tmp_src) + 24'd1);

        // stage 5
        n_stg[5].nx  = (28'(r_stg[4].l1) + 28'd1) * 28'd4000;
        tmp_t        = 4'(r_stg[4].s6[5:3]) + 4'(r_stg[4].s6[2:0]);
        tmp_t2       = 3'(tmp_t[3]) + tmp_t[2:0];
        tmp_res      = (tmp_t2 == 3'd7) ? 3'd0 : tmp_t2;
        n_stg[5].dow = r_stg[4].below ? 3'd0 : tmp_res + 3'd1;

        // stage 6
        n_stg[6].xp = 40'(r_stg[5].nx) * 40'(RECIP_1461001);

        // stage 7
        n_stg[7].x  = r_stg[6].xp[39:32];
        tmp_xd      = 29'(r_stg[6].xp[39:32]) * 29'(DAYS_4000Y);
        tmp_rx      = 29'(r_stg[6].nx) - tmp_xd;
        n_stg[7].rx = tmp_rx[21:0];

        // stage 8
        n_stg[8].x = r_stg[7].x + 8'(r_stg[7].rx >= 22'(DAYS_4000Y));

        // stage 9
        tmp_p       = 19'(r_stg[8].x) * 19'd1461;
        tmp_l2      = 17'(r_stg[8].l1) + 17'd31 - 17'(tmp_p[18:2]);
        n_stg[9].l2 = tmp_l2[9:0];

        // stage 10
        n_stg[10].vn = 17'(r_stg[9].l2) * 17'd80;

        // stage 11
        n_stg[11].vp = 26'(r_stg[10].vn) * 26'(RECIP_2447);

        // stage 12
        n_stg[12].v  = r_stg[11].vp[25:20];
        tmp_vd       = 18'(r_stg[11].vp[25:20]) * 18'(D_2447);
        tmp_rv       = 18'(r_stg[11].vn) - tmp_vd;
        n_stg[12].rv = tmp_rv[12:0];

        // stage 13
        n_stg[13].v = r_stg[12].v + 6'(r_stg[12].rv >= 13'(D_2447));

        // stage 14: result beat
        tmp_u  = r_stg[13].v >= 6'd11;
        tmp_yr = 16'(r_stg[13].w) * 16'd100 + 16'(r_stg[13].x) + 16'(tmp_u) - 16'd4900;
        tmp_dd = r_stg[13].l2 - 10'(dec_mday(r_stg[13].v[3:0]));
        n_stg[14].rsp.day_of_week = r_stg[13].dow;
        if (r_stg[13].op == OP_DECODE) begin
            n_stg[14].rsp.julian_out = 23'd0;
            if (r_stg[13].below) begin
                n_stg[14].rsp.year_out  = 15'd0;
                n_stg[14].rsp.month_out = 4'd0;
                n_stg[14].rsp.day_out   = 5'd0;
            end else begin
                n_stg[14].rsp.year_out  = tmp_yr[14:0];
                n_stg[14].rsp.month_out = r_stg[13].v[3:0] + 4'd2 - (tmp_u ? 4'd12 : 4'd0);
                n_stg[14].rsp.day_out   = tmp_dd[4:0];
            end
        end else begin
            n_stg[14].rsp.julian_out = r_stg[13].jde;
            n_stg[14].rsp.year_out   = 15'd0;
            n_stg[14].rsp.month_out  = 4'd0;
            n_stg[14].rsp.day_out    = 5'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NSTG; k++) begin
            if (ctl.adv[k]) begin
                r_stg[k] <= n_stg[k];
            end
        end
    end

    assign o_rsp.payload = r_stg[NSTG-1].rsp;

endmodule
